// ----- rtl/mdct_pkg.sv -----
// Shared types and constants for the muon decay coincidence timer.
// No dependencies; every other file of the block imports this package.
package mdct_pkg;

    localparam int unsigned WIN_W   = 24;
    localparam int unsigned PS_W    = 32;
    localparam int unsigned TIME_W  = 64;
    localparam int unsigned CH_W    = 4;
    localparam int unsigned CFG_W   = 32;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LIFE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GATE     = 2'd2;

    localparam logic [WIN_W-1:0] RST_WINDOW   = 24'd100000;
    localparam logic [PS_W-1:0]  RST_MAX_LIFE = 32'd20000000;
    localparam logic [PS_W-1:0]  RST_GATE     = 32'd0;

    localparam logic [CH_W-1:0] CH_A = 4'd1;
    localparam logic [CH_W-1:0] CH_B = 4'd2;
    localparam logic [CH_W-1:0] CH_C = 4'd3;

    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QPTR_W = $clog2(QDEPTH);
    localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [CH_W-1:0]   hit_channel;
        logic [TIME_W-1:0] hit_time;
        logic              last_hit;
    } t_hit;

    typedef struct packed {
        logic [PS_W-1:0] lifetime;
    } t_life;

    typedef struct packed {
        logic a;
        logic b;
        logic c;
    } t_flags;

    // One queue entry: an event closed mid-stream and/or the final event.
    typedef struct packed {
        logic              close_v;
        logic [TIME_W-1:0] close_first;
        t_flags            close_flags;
        logic              final_v;
        logic [TIME_W-1:0] final_first;
        t_flags            final_flags;
        logic [TIME_W-1:0] final_from_close;
    } t_rec;

endpackage

// ----- rtl/mdct_hit_if.sv -----
// Hit request channel: valid/ready handshake carrying one TDC hit.
// Depends on mdct_pkg.
interface mdct_hit_if;
    import mdct_pkg::*;
    logic valid;
    logic ready;
    t_hit payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/mdct_life_if.sv -----
// Lifetime request channel: valid/ready handshake carrying one lifetime.
// Depends on mdct_pkg.
interface mdct_life_if;
    import mdct_pkg::*;
    logic valid;
    logic ready;
    t_life payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/mdct_front.sv -----
// Front end: groups hits into events and queues closed events.
// Depends on mdct_pkg and mdct_hit_if.
module mdct_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    mdct_hit_if.sink                  i_hit,
    input  logic [mdct_pkg::WIN_W-1:0] i_window,
    input  logic                      i_full,
    output logic                      o_push,
    output mdct_pkg::t_rec            o_rec
);
    import mdct_pkg::*;

    logic              r_open;
    logic [TIME_W-1:0] r_first;
    t_flags            r_flags;

    logic              accept;
    logic [TIME_W-1:0] diff;
    logic              close;
    logic              fresh;
    logic [TIME_W-1:0] new_first;
    t_flags            hit_flags;
    t_flags            new_flags;

    assign i_hit.ready = !i_full;
    assign accept      = i_hit.valid && !i_full;

    always_comb begin
        diff      = i_hit.payload.hit_time - r_first;
        close     = r_open && (diff > {{(TIME_W-WIN_W){1'b0}}, i_window});
        fresh     = close || !r_open;
        new_first = fresh ? i_hit.payload.hit_time : r_first;
        hit_flags.a = (i_hit.payload.hit_channel == CH_A);
        hit_flags.b = (i_hit.payload.hit_channel == CH_B);
        hit_flags.c = (i_hit.payload.hit_channel == CH_C);
        new_flags = (fresh ? t_flags'('0) : r_flags) | hit_flags;
    end

    always_comb begin
        o_rec.close_v          = close;
        o_rec.close_first      = r_first;
        o_rec.close_flags      = r_flags;
        o_rec.final_v          = i_hit.payload.last_hit;
        o_rec.final_first      = new_first;
        o_rec.final_flags      = new_flags;
        // when the event closed, the new event starts at this hit: same difference
        o_rec.final_from_close = diff;
    end

    assign o_push = accept && (close || i_hit.payload.last_hit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open  <= 1'b0;
            r_first <= '0;
            r_flags <= '0;
        end else if (accept) begin
            if (i_hit.payload.last_hit) begin
                r_open  <= 1'b0;
                r_first <= '0;
                r_flags <= '0;
            end else begin
                r_open  <= 1'b1;
                r_first <= new_first;
                r_flags <= new_flags;
            end
        end
    end

endmodule

// ----- rtl/mdct_queue.sv -----
// Short event queue between front and back end.
// Depends on mdct_pkg.
module mdct_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  mdct_pkg::t_rec i_rec,
    input  logic           i_pop,
    output mdct_pkg::t_rec o_rec,
    output logic           o_full,
    output logic           o_empty
);
    import mdct_pkg::*;

    t_rec              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == QCNT_W'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_rec   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ----- rtl/mdct_back.sv -----
// Back end: arm/disarm logic on closed events, lifetime output register.
// Depends on mdct_pkg and mdct_life_if.
module mdct_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  mdct_pkg::t_rec            i_rec,
    input  logic                      i_empty,
    input  logic [mdct_pkg::PS_W-1:0] i_gate,
    input  logic [mdct_pkg::PS_W-1:0] i_max_life,
    output logic                      o_pop,
    mdct_life_if.source               o_life
);
    import mdct_pkg::*;

    logic              r_armed;
    logic [TIME_W-1:0] r_start;
    logic              r_out_valid;
    logic [PS_W-1:0]   r_out_life;

    logic [TIME_W-1:0] gate_x;
    logic [TIME_W-1:0] max_x;
    logic [TIME_W-1:0] d_close;
    logic [TIME_W-1:0] d_final;
    logic              in_gate;
    logic              bad;
    logic              just_armed;
    logic              armed_mid;
    logic [TIME_W-1:0] start_mid;
    logic              emit_close;
    logic              emit_final;
    logic              emit;
    logic [PS_W-1:0]   life;

    always_comb begin
        gate_x  = {{(TIME_W-PS_W){1'b0}}, i_gate};
        max_x   = {{(TIME_W-PS_W){1'b0}}, i_max_life};
        d_close = i_rec.close_first - r_start;
        in_gate = d_close < gate_x;
        bad     = (d_close > max_x) || i_rec.close_flags.a || i_rec.close_flags.c;

        just_armed = i_rec.close_v && !r_armed &&
                     i_rec.close_flags.a && i_rec.close_flags.b && !i_rec.close_flags.c;
        emit_close = i_rec.close_v && r_armed && !in_gate && !bad && i_rec.close_flags.b;

        if (!i_rec.close_v) begin
            armed_mid = r_armed;
        end else if (r_armed) begin
            armed_mid = in_gate || (!bad && !i_rec.close_flags.b);
        end else begin
            armed_mid = just_armed;
        end
        start_mid = just_armed ? i_rec.close_first : r_start;

        d_final    = just_armed ? i_rec.final_from_close : (i_rec.final_first - r_start);
        emit_final = i_rec.final_v && armed_mid && (d_final > gate_x) &&
                     (d_final <= max_x) && i_rec.final_flags.b &&
                     !i_rec.final_flags.a && !i_rec.final_flags.c;

        emit = emit_close || emit_final;
        life = emit_close ? d_close[PS_W-1:0] : d_final[PS_W-1:0];
    end

    assign o_pop          = !i_empty && (!r_out_valid || o_life.ready);
    assign o_life.valid   = r_out_valid;
    assign o_life.payload.lifetime = r_out_life;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed     <= 1'b0;
            r_start     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_armed <= armed_mid && !i_rec.final_v;
                r_start <= i_rec.final_v ? '0 : start_mid;
            end
            if (o_pop && emit) begin
                r_out_valid <= 1'b1;
            end else if (o_life.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && emit) begin
            r_out_life <= life;
        end
    end

endmodule

// ----- rtl/muon_decay_coincidence_timer.sv -----
// Muon decay coincidence timer, top level: config registers, front, queue, back.
// Depends on mdct_pkg, mdct_hit_if, mdct_life_if, mdct_front, mdct_queue, mdct_back.
//
// Feed time-sorted TDC hits on i_hit; one hit is taken per clock cycle while
// the queue is not full. A lifetime request is valid on o_life from the clock
// edge after the one that accepts the deciding hit (the hit that closes the
// event, or the last hit), provided the queue ahead of it is empty and o_life
// is not stalled. Hits falling within coincidence_window_ps of an event's
// first hit join that event; the next hit outside the window closes it. An
// event with detectors A (channel 1) and B (channel 2) but not C (channel 3)
// arms the block and marks the start time. While armed, events inside
// decay_gate_ps are ignored; an event past max_lifetime_ps or holding A or C
// disarms; a B-only event emits its lifetime (first-hit time minus start)
// and disarms. A hit with last_hit set closes the final event, which emits only
// when strictly past the gate and within the timeout, and then returns the block to
// its reset stream state (registers keep their values). The front end handles one
// hit per cycle unless stalled, limited by a single 64-bit subtract and compare;
// the back end drains one queued event per cycle unless stalled. A four-entry queue
// between them and an output register let each side stall on its own. Write the
// configuration registers only while no hit is in flight.
module muon_decay_coincidence_timer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    mdct_hit_if.sink                      i_hit,
    mdct_life_if.source                   o_life,
    input  logic                          i_cfg_we,
    input  logic [mdct_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [mdct_pkg::CFG_W-1:0]     i_cfg_data
);
    import mdct_pkg::*;

    // configuration registers
    logic [WIN_W-1:0] r_window;
    logic [PS_W-1:0]  r_max_life;
    logic [PS_W-1:0]  r_gate;

    // front to queue
    logic push;
    t_rec push_rec;
    logic full;

    // queue to back
    logic pop;
    t_rec head_rec;
    logic empty;

    // Write registers; indexes beyond the list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window   <= RST_WINDOW;
            r_max_life <= RST_MAX_LIFE;
            r_gate     <= RST_GATE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_WINDOW:   r_window   <= i_cfg_data[WIN_W-1:0];
                CFG_MAX_LIFE: r_max_life <= i_cfg_data[PS_W-1:0];
                CFG_GATE:     r_gate     <= i_cfg_data[PS_W-1:0];
                default: ;
            endcase
        end
    end

    // Group hits into events; push each close (and the final event) to the queue.
    mdct_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_hit    (i_hit),
        .i_window (r_window),
        .i_full   (full),
        .o_push   (push),
        .o_rec    (push_rec)
    );

    // Hold closed events until the back end is free.
    mdct_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_rec   (push_rec),
        .i_pop   (pop),
        .o_rec   (head_rec),
        .o_full  (full),
        .o_empty (empty)
    );

    // Advance the arm/disarm state and register lifetimes for output.
    mdct_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rec      (head_rec),
        .i_empty    (empty),
        .i_gate     (r_gate),
        .i_max_life (r_max_life),
        .o_pop      (pop),
        .o_life     (o_life)
    );

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// Testbench for the muon decay coincidence timer: drives TDC hit requests,
// predicts lifetime requests and checks them. Depends on mdct_pkg, the two
// channel interfaces and the muon_decay_coincidence_timer top level.
module tb;
    import mdct_pkg::*;

    // Cycles allowed after the last expected lifetime before a config write
    // or the end: covers hits still in the front end, queue and back end.
    localparam int unsigned SETTLE_CYCLES = 32;
    localparam int unsigned PHASE_HITS    = 80;

    logic                 i_clk    = 1'b0;
    logic                 i_rst_n  = 1'b0;
    logic                 cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx  = '0;
    logic [CFG_W-1:0]     cfg_data = '0;

    mdct_hit_if  hit_if ();
    mdct_life_if life_if ();

    muon_decay_coincidence_timer i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_hit      (hit_if),
        .o_life     (life_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // Hits waiting for the driver, and lifetimes owed by the block.
    t_hit            hits_pending [$];
    logic [PS_W-1:0] lifetimes_due [$];

    int unsigned err_cnt    = 0;
    int unsigned hits_built = 0;
    int unsigned idle_odds  = 4;    // chance out of 16 to start an idle burst
    bit          calm       = 1'b0; // no idling on either side
    int unsigned send_gap   = 0;
    int unsigned recv_stall = 0;
    logic [TIME_W-1:0] cur_t = 64'd1000;

    // Predictor copy of the registers and the event tracker.
    logic [WIN_W-1:0]  win_ps      = RST_WINDOW;
    logic [PS_W-1:0]   max_life_ps = RST_MAX_LIFE;
    logic [PS_W-1:0]   gate_ps     = RST_GATE;
    bit                ev_open     = 1'b0;
    logic [TIME_W-1:0] ev_first    = '0;
    bit                has_a       = 1'b0;
    bit                has_b       = 1'b0;
    bit                has_c       = 1'b0;
    bit                muon_armed  = 1'b0;
    logic [TIME_W-1:0] muon_start  = '0;

    initial begin
        hit_if.valid   = 1'b0;
        hit_if.payload = '0;
        life_if.ready  = 1'b0;
    end

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Classify an event closed mid-stream; return 1 when it yields a lifetime.
    function automatic bit judge_event(output logic [PS_W-1:0] life);
        logic [TIME_W-1:0] d;
        life = '0;
        if (!muon_armed) begin
            // Idle: A and B without C is a stopping muon, so arm.
            if (has_a && has_b && !has_c) begin
                muon_armed = 1'b1;
                muon_start = ev_first;
            end
            return 1'b0;
        end
        d = ev_first - muon_start;
        if (d < gate_ps)
            return 1'b0;
        if (d > max_life_ps || has_a || has_c) begin
            muon_armed = 1'b0;
            return 1'b0;
        end
        if (has_b) begin
            life       = d[PS_W-1:0];
            muon_armed = 1'b0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Advance the event tracker by one accepted hit; return 1 when a lifetime
    // request is owed for it.
    function automatic bit lifetime_from_hit(input t_hit h, output logic [PS_W-1:0] life);
        logic [TIME_W-1:0] d;
        bit                emit;
        emit = 1'b0;
        life = '0;
        if (ev_open && (h.hit_time - ev_first) > win_ps) begin
            emit    = judge_event(life);
            ev_open = 1'b0;
        end
        if (!ev_open) begin
            ev_open  = 1'b1;
            ev_first = h.hit_time;
            has_a    = 1'b0;
            has_b    = 1'b0;
            has_c    = 1'b0;
        end
        if (h.hit_channel == CH_A) has_a = 1'b1;
        if (h.hit_channel == CH_B) has_b = 1'b1;
        if (h.hit_channel == CH_C) has_c = 1'b1;
        if (h.last_hit) begin
            // Final event: strictly past the gate, within the timeout, B only.
            if (muon_armed) begin
                d = ev_first - muon_start;
                if (d > gate_ps && d <= max_life_ps && has_b && !has_a && !has_c) begin
                    life = d[PS_W-1:0];
                    emit = 1'b1;
                end
            end
            // Back to a fresh stream; registers stay.
            ev_open    = 1'b0;
            ev_first   = '0;
            has_a      = 1'b0;
            has_b      = 1'b0;
            has_c      = 1'b0;
            muon_armed = 1'b0;
            muon_start = '0;
        end
        return emit;
    endfunction

    // Hit driver: hold the request until taken, then pop the next one or idle.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hit_if.valid <= 1'b0;
            send_gap     <= 0;
        end else if (!hit_if.valid || hit_if.ready) begin
            if (send_gap != 0 && !calm) begin
                send_gap     <= send_gap - 1;
                hit_if.valid <= 1'b0;
            end else if (!calm && $urandom_range(0, 15) < idle_odds) begin
                // Start an idle burst.
                send_gap     <= $urandom_range(0, 5);
                hit_if.valid <= 1'b0;
            end else if (hits_pending.size() != 0) begin
                hit_if.payload <= hits_pending.pop_front();
                hit_if.valid   <= 1'b1;
            end else begin
                hit_if.valid <= 1'b0;
            end
        end
    end

    // Lifetime sink: stall in bursts.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            life_if.ready <= 1'b0;
            recv_stall    <= 0;
        end else if (recv_stall != 0 && !calm) begin
            recv_stall    <= recv_stall - 1;
            life_if.ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 15) < idle_odds) begin
            recv_stall    <= $urandom_range(0, 5);
            life_if.ready <= 1'b0;
        end else begin
            life_if.ready <= 1'b1;
        end
    end

    // Predict on every accepted hit, compare every accepted lifetime.
    always @(posedge i_clk) begin : check_lifetimes
        logic [PS_W-1:0] owed;
        logic [PS_W-1:0] want;
        if (i_rst_n) begin
            if (hit_if.valid && hit_if.ready) begin
                if (lifetime_from_hit(hit_if.payload, owed))
                    lifetimes_due.insert(lifetimes_due.size(), owed);
            end
            if (life_if.valid && life_if.ready) begin
                if (lifetimes_due.size() == 0) begin
                    $display("%0t: unexpected lifetime, expected none, actual %0d",
                             $time, life_if.payload.lifetime);
                    err_cnt++;
                end else begin
                    want = lifetimes_due.pop_front();
                    if (life_if.payload.lifetime !== want) begin
                        $display("%0t: lifetime mismatch, expected %0d, actual %0d",
                                 $time, want, life_if.payload.lifetime);
                        err_cnt++;
                    end
                end
            end
        end
    end

    function automatic logic [TIME_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [TIME_W-1:0] pick_between(input logic [TIME_W-1:0] lo,
                                                       input logic [TIME_W-1:0] hi);
        if (hi <= lo)
            return lo;
        return lo + rand64() % (hi - lo + 64'd1);
    endfunction

    task automatic push_hit(input logic [CH_W-1:0] ch, input logic [TIME_W-1:0] t,
                            input logic last);
        t_hit h;
        h.hit_channel = ch;
        h.hit_time    = t;
        h.last_hit    = last;
        hits_pending.insert(hits_pending.size(), h);
        hits_built++;
    endtask

    // Write all three registers on back-to-back edges and track them.
    task automatic set_config(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] m,
                              input logic [CFG_W-1:0] g);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_WINDOW;
        cfg_data <= w;
        @(posedge i_clk);
        cfg_idx  <= CFG_MAX_LIFE;
        cfg_data <= m;
        @(posedge i_clk);
        cfg_idx  <= CFG_GATE;
        cfg_data <= g;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        win_ps      = w[WIN_W-1:0];
        max_life_ps = m;
        gate_ps     = g;
    endtask

    // Hold until every request is sent and every lifetime is back, then let
    // any hit that owes nothing drain out of the pipeline.
    task automatic wait_idle();
        do
            @(negedge i_clk);
        while (hits_pending.size() != 0 || hit_if.valid || lifetimes_due.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // One stopping muon: start event, optional stray event, end event whose
    // distance is aimed at the gate and timeout edges or between them.
    task automatic gen_decay();
        logic [TIME_W-1:0] s;
        logic [TIME_W-1:0] d;
        logic [TIME_W-1:0] t;
        logic [TIME_W-1:0] w;
        logic [CH_W-1:0]   ch;
        int unsigned       kind;
        bit                fin;
        w = TIME_W'(win_ps);
        s = cur_t;
        if ($urandom_range(0, 1)) begin
            push_hit(CH_A, s, 1'b0);
            push_hit(CH_B, s + pick_between(64'd0, w), 1'b0);
        end else begin
            push_hit(CH_B, s, 1'b0);
            push_hit(CH_A, s + pick_between(64'd0, w), 1'b0);
        end
        // Spoil the start now and then with C or a stray channel.
        if ($urandom_range(0, 7) == 0)
            push_hit($urandom_range(0, 1) ? CH_C : CH_W'($urandom_range(4, 15)), s + w, 1'b0);

        kind = $urandom_range(0, 9);
        case (kind)
            0:       d = TIME_W'(gate_ps);
            1:       d = TIME_W'(max_life_ps);
            2:       d = TIME_W'(max_life_ps) + 64'd1;
            3:       d = TIME_W'(gate_ps - PS_W'(gate_ps != 0));
            default: d = pick_between(TIME_W'(gate_ps), TIME_W'(max_life_ps));
        endcase
        if (d <= w)
            d = w + 64'd1 + $urandom_range(0, 1000);

        if ($urandom_range(0, 3) == 0 && d > 2 * w + 2)
            push_hit(CH_W'($urandom_range(0, 15)), s + pick_between(w + 1, d - w - 1), 1'b0);

        t    = s + d;
        fin  = ($urandom_range(0, 5) == 0);
        kind = $urandom_range(0, 7);
        ch   = (kind == 0) ? CH_A : (kind == 1) ? CH_C :
               (kind == 2) ? CH_W'($urandom_range(4, 15)) : CH_B;
        if ($urandom_range(0, 2) == 0) begin
            push_hit(ch, t, 1'b0);
            push_hit($urandom_range(0, 1) ? CH_B : CH_W'($urandom_range(0, 15)),
                     t + pick_between(64'd0, w), fin);
        end else begin
            push_hit(ch, t, fin);
        end
        cur_t = t + w + 64'd1 + $urandom_range(0, 5000);
        // Start a new stream anywhere on the 64-bit time axis.
        if (fin && $urandom_range(0, 3) == 0)
            cur_t = rand64();
    endtask

    // Stray hit: any channel, joining, closing or stepping back in time.
    task automatic gen_noise();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0)
            cur_t = cur_t - $urandom_range(1, 100000);
        else if (r < 4)
            cur_t = cur_t + pick_between(64'd0, TIME_W'(win_ps));
        else
            cur_t = cur_t + win_ps + 64'd1 + $urandom_range(0, 200000);
        push_hit(CH_W'($urandom_range(0, 15)), cur_t, $urandom_range(0, 19) == 0);
    endtask

    task automatic run_phase(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] m,
                             input logic [CFG_W-1:0] g, input int unsigned odds);
        int unsigned first;
        set_config(w, m, g);
        idle_odds = odds;
        first     = hits_built;
        while (hits_built - first < PHASE_HITS) begin
            if ($urandom_range(0, 4) == 0)
                gen_noise();
            else
                gen_decay();
        end
        // Close the stream so no event is left open across a config change.
        push_hit(CH_W'($urandom_range(0, 15)), cur_t + win_ps + 64'd1, 1'b1);
        cur_t = cur_t + win_ps + 64'd2;
        wait_idle();
    endtask

    // Directed hits at the reset settings (window 100 ns, timeout 20 us).
    task automatic run_directed();
        // Plain decay: arm on A+B, B-only event emits when the next hit closes it.
        push_hit(CH_A, 64'd0, 1'b0);
        push_hit(CH_B, 64'd50, 1'b0);
        push_hit(CH_B, 64'd1_000_000, 1'b0);
        push_hit(4'd0, 64'd2_000_000, 1'b0);
        // Hit exactly at the window edge joins; a C event disarms.
        push_hit(CH_A, 64'd3_000_000, 1'b0);
        push_hit(CH_B, 64'd3_100_000, 1'b0);
        push_hit(CH_C, 64'd4_000_000, 1'b0);
        push_hit(CH_B, 64'd5_000_000, 1'b0);
        // Lifetime exactly at the timeout still emits.
        push_hit(CH_A, 64'd9_000_000, 1'b0);
        push_hit(CH_B, 64'd9_000_000, 1'b0);
        push_hit(CH_B, 64'd29_000_000, 1'b0);
        push_hit(4'd4, 64'd30_000_000, 1'b0);
        // One past the timeout disarms.
        push_hit(CH_A, 64'd31_000_000, 1'b0);
        push_hit(CH_B, 64'd31_000_000, 1'b0);
        push_hit(CH_B, 64'd51_000_001, 1'b0);
        push_hit(4'd15, 64'd52_000_000, 1'b0);
        // Last hit joins the start event, so the final event does not emit.
        push_hit(CH_A, 64'd60_000_000, 1'b0);
        push_hit(CH_B, 64'd60_000_000, 1'b0);
        push_hit(CH_B, 64'd60_005_000, 1'b1);
        // Time going backwards looks like a huge distance.
        push_hit(CH_A, 64'd10, 1'b0);
        push_hit(CH_B, 64'd20, 1'b0);
        push_hit(CH_B, 64'd5, 1'b0);
        push_hit(4'd0, 64'd200_000, 1'b1);
        // Start near the top of the time axis, end after the wrap.
        push_hit(CH_A, 64'hFFFF_FFFF_FFFF_FF9C, 1'b0);
        push_hit(CH_B, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        push_hit(CH_B, 64'd500_000, 1'b1);
        wait_idle();
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();

        // Extremes first: zero window with junk above bit 23, widest timeout.
        run_phase(32'hA500_0000, 32'hFFFF_FFFF, 32'd0, 3);
        run_phase(32'h00FF_FFFF, 32'd20_000_000, 32'd0, 6);
        // Zero timeout: only distance zero survives, and finals never emit.
        run_phase(32'd1000, 32'd0, 32'd0, 2);
        // Gate at its maximum swallows every armed event short of 2^32-1 ps after the start.
        run_phase($urandom_range(0, 200000), $urandom_range(1_000_000, 30_000_000),
                  32'hFFFF_FFFF, 4);
        // Stream crossing the wrap of the time axis, no idling.
        cur_t = 64'hFFFF_FFFF_FF00_0000;
        run_phase($urandom_range(0, 200000), $urandom_range(2_000_000, 30_000_000),
                  $urandom_range(0, 1_000_000), 0);
        run_phase($urandom, $urandom, $urandom, 5);
        run_phase({8'($urandom_range(0, 255)), 24'(0)} | $urandom_range(0, 200000),
                  $urandom_range(500_000, 30_000_000), $urandom_range(0, 500_000), 3);
        // Last stretch runs with both sides always ready.
        calm = 1'b1;
        run_phase($urandom_range(0, 150000), $urandom_range(1_000_000, 25_000_000),
                  32'd0, 0);

        if (err_cnt == 0 && lifetimes_due.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/mdct_pkg.sv
rtl/mdct_hit_if.sv
rtl/mdct_life_if.sv
rtl/mdct_front.sv
rtl/mdct_queue.sv
rtl/mdct_back.sv
rtl/muon_decay_coincidence_timer.sv
tb/tb.sv
